@@ src/etf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etf_pkg
// Shared types and constants of the escape-time fractal shader.
// ----------------------------------------------------------------------------
package etf_pkg;

  localparam int unsigned COORD_W = 32;   // Q4.28 plane coordinate
  localparam int unsigned PIX_W   = 10;
  localparam int unsigned STEP_W  = 31;
  localparam int unsigned LIMIT_W = 13;
  localparam int unsigned RGB_W   = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIFF_W  = 14;   // 2*pixel - image size, signed
  localparam int unsigned PROD_W  = 46;   // DIFF_W x (STEP_W+1)
  localparam int unsigned SQ_W    = 64;   // Q8.56 square or product
  localparam int unsigned NUM_W   = 21;   // 255 * (limit - i)
  localparam int unsigned SHADE_W = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_REAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_IMAG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_REAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_IMAG  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT  = 3'd5;

  localparam logic [STEP_W-1:0]  RESET_STEP  = 31'd1048576;
  localparam logic [LIMIT_W-1:0] RESET_LIMIT = 13'd100;

  localparam logic [SQ_W-1:0]  ESCAPE_RADIUS_SQ = 64'h0400_0000_0000_0000;
  localparam logic [RGB_W-1:0] COLOR_WHITE      = 24'hFF_FFFF;

  typedef struct packed {
    logic        [STEP_W-1:0]  pixel_step;
    logic signed [COORD_W-1:0] offset_real;
    logic signed [COORD_W-1:0] offset_imag;
    logic signed [COORD_W-1:0] start_real;
    logic signed [COORD_W-1:0] start_imag;
    logic        [LIMIT_W-1:0] iteration_limit;
  } cfg_t;

  typedef struct packed {
    logic        [PIX_W-1:0]   x;
    logic        [PIX_W-1:0]   y;
    logic signed [COORD_W-1:0] c_real;
    logic signed [COORD_W-1:0] c_imag;
  } item_t;

  // Clamp a wide signed value to the signed 32-bit coordinate range.
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sh0_7FFF_FFFF;
    lo = -66'sh0_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return -32'sh8000_0000;
    end
    return v[COORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ src/etf_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etf_front
// Accepts a pixel and maps it to its point c of the complex plane.
// ----------------------------------------------------------------------------
module etf_front #(
  parameter int unsigned IMAGE_SIZE = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [etf_pkg::PIX_W-1:0]    pixel_x_i,
  input  wire logic [etf_pkg::PIX_W-1:0]    pixel_y_i,
  input  wire etf_pkg::cfg_t                cfg_i,
  output logic                              busy_o,
  output logic                              push_o,
  output etf_pkg::item_t                    item_o,
  input  wire logic                         full_i
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MULX = 2'd1;
  localparam logic [1:0] F_MULY = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0] state_q, state_d;
  logic [etf_pkg::PIX_W-1:0] x_q, y_q;
  logic signed [etf_pkg::PROD_W-1:0] prod_q;
  logic signed [etf_pkg::COORD_W-1:0] cr_q;

  logic [etf_pkg::PIX_W-1:0] pix_sel;
  logic signed [etf_pkg::DIFF_W-1:0] diff;
  logic signed [etf_pkg::COORD_W:0] step_s;
  logic signed [etf_pkg::PROD_W-1:0] prod_d;
  logic signed [etf_pkg::COORD_W-1:0] offset_sel;
  logic signed [etf_pkg::COORD_W-1:0] mapped;
  logic accept;

  assign accept = start_i && (state_q == F_IDLE);
  assign busy_o = (state_q != F_IDLE);

  // Multiplier is shared by the two axes, one after the other.
  always_comb begin
    pix_sel = (state_q == F_MULX) ? x_q : y_q;
    diff    = $signed({{(etf_pkg::DIFF_W-etf_pkg::PIX_W-1){1'b0}}, pix_sel, 1'b0})
              - $signed(etf_pkg::DIFF_W'(IMAGE_SIZE));
    step_s  = $signed({2'b00, cfg_i.pixel_step});
    prod_d  = etf_pkg::PROD_W'(diff) * etf_pkg::PROD_W'(step_s);
    offset_sel = (state_q == F_PUSH) ? cfg_i.offset_imag : cfg_i.offset_real;
    // Arithmetic shift gives the halving with rounding toward minus infinity.
    mapped  = etf_pkg::sat_coord(66'(prod_q >>> 1) + 66'(offset_sel));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (start_i) begin
          state_d = F_MULX;
        end
      end
      F_MULX: state_d = F_MULY;
      F_MULY: state_d = F_PUSH;
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= pixel_x_i;
      y_q <= pixel_y_i;
    end
    if (state_q == F_MULX || state_q == F_MULY) begin
      prod_q <= prod_d;
    end
    if (state_q == F_MULY) begin
      cr_q <= mapped;
    end
  end

  assign push_o        = (state_q == F_PUSH) && !full_i;
  assign item_o.x      = x_q;
  assign item_o.y      = y_q;
  assign item_o.c_real = cr_q;
  assign item_o.c_imag = mapped;

endmodule
`default_nettype wire

@@ src/etf_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etf_queue
// Short first-in first-out queue of mapped pixels between front and core.
// ----------------------------------------------------------------------------
module etf_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire etf_pkg::item_t  item_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output etf_pkg::item_t       item_o,
  output logic                 empty_o
);

  localparam int unsigned PTR_W = $clog2(etf_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(etf_pkg::QUEUE_DEPTH + 1);

  etf_pkg::item_t    mem_q [etf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr_q, rptr_q;
  logic [CNT_W-1:0]  count_q;

  assign full_o  = (count_q == CNT_W'(etf_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_W'(etf_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTR_W'(etf_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

@@ src/etf_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etf_core
// Iterates z = z^2 + c for one pixel, then works out its shade.
// ----------------------------------------------------------------------------
module etf_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire etf_pkg::cfg_t                cfg_i,
  input  wire logic                         empty_i,
  input  wire etf_pkg::item_t               item_i,
  output logic                              pop_o,
  output logic                              result_valid_o,
  output logic [etf_pkg::PIX_W-1:0]         out_x_o,
  output logic [etf_pkg::PIX_W-1:0]         out_y_o,
  output logic [etf_pkg::RGB_W-1:0]         rgb_color_o,
  output logic [etf_pkg::LIMIT_W-1:0]       iteration_count_o,
  output logic                              inside_res_o
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_SQR  = 2'd1;
  localparam logic [1:0] C_UPD  = 2'd2;
  localparam logic [1:0] C_DIV  = 2'd3;

  localparam int unsigned LW = etf_pkg::LIMIT_W;

  logic [1:0] state_q, state_d;
  logic [etf_pkg::PIX_W-1:0] x_q, y_q;
  logic signed [etf_pkg::COORD_W-1:0] cr_q, ci_q, zr_q, zi_q;
  logic signed [etf_pkg::SQ_W-1:0] rr_q, ii_q, ri_q;
  logic [LW-1:0] cnt_q;
  logic [etf_pkg::NUM_W-1:0] rem_q;
  logic [2:0] bit_q;
  logic [etf_pkg::SHADE_W-1:0] quot_q;
  logic valid_q;
  logic [etf_pkg::RGB_W-1:0] rgb_q;
  logic [LW-1:0] count_out_q;
  logic inside_q;

  logic [LW-1:0] lim_eff;
  logic [etf_pkg::SQ_W-1:0] mag;
  logic escape;
  logic last_iter;
  logic signed [64:0] re_diff;
  logic signed [etf_pkg::COORD_W-1:0] nr, ni;
  logic [LW-1:0] left;
  logic [etf_pkg::NUM_W-1:0] num;
  logic [etf_pkg::NUM_W-1:0] trial;
  logic take;
  logic [etf_pkg::SHADE_W-1:0] quot_next;

  assign lim_eff = (cfg_i.iteration_limit == '0) ? LW'(1) : cfg_i.iteration_limit;
  assign pop_o   = (state_q == C_IDLE) && !empty_i;

  always_comb begin
    // Squares of the z held now; rr + ii tests the z from the previous update.
    mag       = $unsigned(rr_q) + $unsigned(ii_q);
    escape    = (cnt_q != '0) && (mag >= etf_pkg::ESCAPE_RADIUS_SQ);
    last_iter = ({1'b0, cnt_q} + 1'b1) >= {1'b0, lim_eff};
    re_diff   = 65'(rr_q) - 65'(ii_q);
    nr        = etf_pkg::sat_coord(66'(re_diff >>> 28) + 66'(cr_q));
    ni        = etf_pkg::sat_coord(66'(ri_q >>> 27) + 66'(ci_q));
    left      = lim_eff - cnt_q;
    num       = {left, 8'b0} - etf_pkg::NUM_W'(left);
    trial     = etf_pkg::NUM_W'({8'b0, lim_eff} << bit_q);
    take      = (rem_q >= trial);
    quot_next = quot_q | (etf_pkg::SHADE_W'(take) << bit_q);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      C_IDLE: begin
        if (!empty_i) begin
          state_d = C_SQR;
        end
      end
      C_SQR: state_d = C_UPD;
      C_UPD: begin
        if (escape) begin
          state_d = C_DIV;
        end else if (last_iter) begin
          state_d = C_IDLE;
        end else begin
          state_d = C_SQR;
        end
      end
      C_DIV: begin
        if (bit_q == '0) begin
          state_d = C_IDLE;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= ((state_q == C_UPD) && !escape && last_iter) ||
                 ((state_q == C_DIV) && (bit_q == '0));
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      C_IDLE: begin
        x_q   <= item_i.x;
        y_q   <= item_i.y;
        cr_q  <= item_i.c_real;
        ci_q  <= item_i.c_imag;
        zr_q  <= cfg_i.start_real;
        zi_q  <= cfg_i.start_imag;
        cnt_q <= '0;
      end
      C_SQR: begin
        rr_q <= etf_pkg::SQ_W'(zr_q * zr_q);
        ii_q <= etf_pkg::SQ_W'(zi_q * zi_q);
        ri_q <= etf_pkg::SQ_W'(zr_q * zi_q);
      end
      C_UPD: begin
        if (escape) begin
          rem_q  <= num;
          bit_q  <= 3'd7;
          quot_q <= '0;
        end else if (last_iter) begin
          rgb_q       <= etf_pkg::COLOR_WHITE;
          count_out_q <= lim_eff;
          inside_q    <= 1'b1;
        end else begin
          zr_q  <= nr;
          zi_q  <= ni;
          cnt_q <= cnt_q + 1'b1;
        end
      end
      C_DIV: begin
        // Restoring division, one quotient bit per cycle, high bit first.
        if (take) begin
          rem_q <= rem_q - trial;
        end
        quot_q <= quot_next;
        bit_q  <= bit_q - 1'b1;
        if (bit_q == '0) begin
          rgb_q       <= {quot_next, quot_next, quot_next};
          count_out_q <= cnt_q;
          inside_q    <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign result_valid_o    = valid_q;
  assign out_x_o           = x_q;
  assign out_y_o           = y_q;
  assign rgb_color_o       = rgb_q;
  assign iteration_count_o = count_out_q;
  assign inside_res_o      = inside_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q)
    else $error("result strobe held longer than one cycle");

  a_inside_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && inside_q) |-> (rgb_q == etf_pkg::COLOR_WHITE && count_out_q == lim_eff))
    else $error("inside pixel without white color or limit count");

  a_escape_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !inside_q) |-> (count_out_q != '0 && count_out_q < lim_eff &&
      rgb_q[23:16] == rgb_q[7:0] && rgb_q[15:8] == rgb_q[7:0]))
    else $error("escaped pixel with bad count or non-gray color");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == C_SQR))
    else $error("popped pixel did not start iterating");

endmodule
`default_nettype wire

@@ src/escape_time_fractal_shader.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escape_time_fractal_shader
// Escape-time shading of one pixel per request, Q4.28 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   A request (pixel_x_i, pixel_y_i) is taken at a clock edge with start_i
//   high and busy_o low. The front maps it to c, real axis then imaginary
//   axis, and places it in a two-entry queue; busy_o stays high while the
//   front works or waits on a full queue. The core loads a queued pixel,
//   then iterates z = z^2 + c, each step being square products, then
//   update and escape test. A pixel that escapes at index i runs i + 1
//   steps and then a bit-serial shade division of eight quotient bits; a
//   pixel that never escapes runs as many steps as the iteration limit.
//   A result is on the output ports for one cycle, marked by result_valid_o.
//   The receiver cannot stall it.
//   The core works on one pixel at a time, and the front takes no new
//   request until it has pushed the previous one into the queue.
//   Configuration writes (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i)
//   are always taken and are meant to happen only while the block is idle.
//   Reset sets the registers to their default values and empties the queue.
// ----------------------------------------------------------------------------
module escape_time_fractal_shader #(
  parameter int unsigned IMAGE_SIZE = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [etf_pkg::PIX_W-1:0]        pixel_x_i,
  input  wire logic [etf_pkg::PIX_W-1:0]        pixel_y_i,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [etf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [etf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                                  result_valid_o,
  output logic [etf_pkg::PIX_W-1:0]             out_x_o,
  output logic [etf_pkg::PIX_W-1:0]             out_y_o,
  output logic [etf_pkg::RGB_W-1:0]             rgb_color_o,
  output logic [etf_pkg::LIMIT_W-1:0]           iteration_count_o,
  output logic                                  inside_res_o
);

  etf_pkg::cfg_t  cfg_q;
  etf_pkg::item_t front_item, queue_item;
  logic push, full, pop, empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_step      <= etf_pkg::RESET_STEP;
      cfg_q.offset_real     <= '0;
      cfg_q.offset_imag     <= '0;
      cfg_q.start_real      <= '0;
      cfg_q.start_imag      <= '0;
      cfg_q.iteration_limit <= etf_pkg::RESET_LIMIT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        etf_pkg::CFG_PIXEL_STEP:  cfg_q.pixel_step  <= cfg_data_i[etf_pkg::STEP_W-1:0];
        etf_pkg::CFG_OFFSET_REAL: cfg_q.offset_real <= $signed(cfg_data_i);
        etf_pkg::CFG_OFFSET_IMAG: cfg_q.offset_imag <= $signed(cfg_data_i);
        etf_pkg::CFG_START_REAL:  cfg_q.start_real  <= $signed(cfg_data_i);
        etf_pkg::CFG_START_IMAG:  cfg_q.start_imag  <= $signed(cfg_data_i);
        etf_pkg::CFG_ITER_LIMIT:
          cfg_q.iteration_limit <= cfg_data_i[etf_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  etf_front #(
    .IMAGE_SIZE (IMAGE_SIZE)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .cfg_i     (cfg_q),
    .busy_o    (busy_o),
    .push_o    (push),
    .item_o    (front_item),
    .full_i    (full)
  );

  etf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (queue_item),
    .empty_o (empty)
  );

  etf_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .empty_i           (empty),
    .item_i            (queue_item),
    .pop_o             (pop),
    .result_valid_o    (result_valid_o),
    .out_x_o           (out_x_o),
    .out_y_o           (out_y_o),
    .rgb_color_o       (rgb_color_o),
    .iteration_count_o (iteration_count_o),
    .inside_res_o      (inside_res_o)
  );

endmodule
`default_nettype wire
